/* design/didc_pkg.sv */
// ----------------------------------------------------------------------------
// didc_pkg
// Shared types and constants for the de-duplicating tag id collector.
// ----------------------------------------------------------------------------
`default_nettype none

package didc_pkg;

   // Default sizes of the storage
   localparam int DEF_MAIN_ENTRIES  = 80;
   localparam int DEF_EXTRA_ENTRIES = 20;
   localparam int DEF_ID_COUNT      = 1024;

   // Transaction codes on the request channel
   localparam logic [1:0] ACT_REPORT = 2'd0;
   localparam logic [1:0] ACT_DUMP   = 2'd1;
   localparam logic [1:0] ACT_PULL   = 2'd2;

   // Frame delimiters and entry tag
   localparam logic [7:0] FRAME_BEGIN = 8'hF0;
   localparam logic [7:0] FRAME_END   = 8'hFE;
   localparam logic [7:0] MAIN_TAG    = 8'h00;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] flag_byte;
      logic [7:0] id_high;
      logic [7:0] id_low;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic report_start;
      logic report_finish;
      logic dump_arm;
      logic pull_emit;
      logic clear_step;
   } didc_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic dumping;
      logic at_end;
      logic clear_done;
   } didc_sts_type;

endpackage

`default_nettype wire

/* design/didc_ctrl.sv */
// ----------------------------------------------------------------------------
// didc_ctrl
// Sequencer: report read-modify-write, dump byte pulls and bitmap clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module didc_ctrl
   import didc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [1:0]   action,
   input  wire didc_sts_type sts,
   output didc_cmd_type      cmd,
   output logic              busy
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_REPORT = 2'd1;
   localparam logic [1:0] ST_PULL   = 2'd2;
   localparam logic [1:0] ST_CLEAR  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (action)
                  ACT_REPORT: begin
                     // drop reports while a dump runs
                     if (!sts.dumping) begin
                        cmd.report_start = 1'b1;
                        state_in         = ST_REPORT;
                     end
                  end
                  ACT_DUMP: begin
                     cmd.dump_arm = !sts.dumping;
                  end
                  ACT_PULL: begin
                     if (sts.dumping) begin
                        state_in = ST_PULL;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_REPORT: begin
            cmd.report_finish = 1'b1;
            state_in          = ST_IDLE;
         end
         ST_PULL: begin
            cmd.pull_emit = 1'b1;
            state_in      = sts.at_end ? ST_CLEAR : ST_IDLE;
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

/* design/didc_datapath.sv */
// ----------------------------------------------------------------------------
// didc_datapath
// Seen bitmap, main and extra lists, counters, dump framing and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module didc_datapath
   import didc_pkg::*;
#(
   parameter int MAIN_ENTRIES  = DEF_MAIN_ENTRIES,
   parameter int EXTRA_ENTRIES = DEF_EXTRA_ENTRIES,
   parameter int ID_COUNT      = DEF_ID_COUNT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire req_type      req_data,
   input  wire didc_cmd_type cmd,
   output didc_sts_type sts,
   output logic        rsp_valid,
   output rsp_type     rsp_data
);

   localparam int IDX_W  = $clog2(ID_COUNT);
   localparam int MIDX_W = (MAIN_ENTRIES > 1) ? $clog2(MAIN_ENTRIES) : 1;
   localparam int EIDX_W = (EXTRA_ENTRIES > 1) ? $clog2(EXTRA_ENTRIES) : 1;
   localparam int MCNT_W = $clog2(MAIN_ENTRIES + 1);
   localparam int ECNT_W = $clog2(EXTRA_ENTRIES + 1);
   localparam int PTR_W  = (MCNT_W > ECNT_W) ? MCNT_W : ECNT_W;

   localparam logic [2:0] PH_HDR0  = 3'd0;
   localparam logic [2:0] PH_HDR1  = 3'd1;
   localparam logic [2:0] PH_HDR2  = 3'd2;
   localparam logic [2:0] PH_MAIN  = 3'd3;
   localparam logic [2:0] PH_EXTRA = 3'd4;
   localparam logic [2:0] PH_END   = 3'd5;

   // Storage
   logic        seen_mem  [ID_COUNT];
   logic [15:0] main_mem  [MAIN_ENTRIES];
   logic [23:0] extra_mem [EXTRA_ENTRIES];

   logic        seen_rd_ff;
   logic [15:0] main_rd_ff;
   logic [23:0] extra_rd_ff;

   // Control registers
   logic [MCNT_W-1:0] main_count_ff,  main_count_in;
   logic [ECNT_W-1:0] extra_count_ff, extra_count_in;
   logic              dumping_ff,     dumping_in;
   logic [2:0]        phase_ff,       phase_in;
   logic [PTR_W-1:0]  dump_idx_ff,    dump_idx_in;
   logic [1:0]        sel_ff,         sel_in;
   logic [IDX_W-1:0]  clr_ff,         clr_in;
   logic              rsp_valid_ff,   rsp_valid_in;

   // Payload registers
   logic [15:0] rep_id_ff;
   logic        rep_in_range_ff;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic [15:0]      req_id;
   logic             req_in_range;
   logic             extra_we;
   logic             main_we;
   logic             seen_we;
   logic [IDX_W-1:0] seen_wa;
   logic             seen_wd;
   logic [8:0]       total_sum;

   assign req_id       = {req_data.id_high, req_data.id_low};
   assign req_in_range = ({1'b0, req_id} < 17'(ID_COUNT));
   assign total_sum    = 9'(main_count_ff) + 9'(extra_count_ff);

   assign extra_we = cmd.report_start && (req_data.flag_byte != 8'd0) &&
                     (extra_count_ff < ECNT_W'(EXTRA_ENTRIES));
   assign main_we  = cmd.report_finish && rep_in_range_ff && !seen_rd_ff &&
                     (main_count_ff < MCNT_W'(MAIN_ENTRIES));

   always_comb begin
      seen_we = 1'b0;
      seen_wa = clr_ff;
      seen_wd = 1'b0;
      if (cmd.clear_step) begin
         seen_we = 1'b1;
      end else if (cmd.report_finish && rep_in_range_ff && !seen_rd_ff) begin
         seen_we = 1'b1;
         seen_wa = rep_id_ff[IDX_W-1:0];
         seen_wd = 1'b1;
      end
   end

   // Memories: one write port each, registered read
   always_ff @(posedge clock) begin
      if (seen_we) begin
         seen_mem[seen_wa] <= seen_wd;
      end
      seen_rd_ff <= seen_mem[req_id[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (main_we) begin
         main_mem[main_count_ff[MIDX_W-1:0]] <= rep_id_ff;
      end
      main_rd_ff <= main_mem[dump_idx_ff[MIDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (extra_we) begin
         extra_mem[extra_count_ff[EIDX_W-1:0]] <= {req_data.flag_byte, req_id};
      end
      extra_rd_ff <= extra_mem[dump_idx_ff[EIDX_W-1:0]];
   end

   always_comb begin
      main_count_in  = main_count_ff;
      extra_count_in = extra_count_ff;
      dumping_in     = dumping_ff;
      phase_in       = phase_ff;
      dump_idx_in    = dump_idx_ff;
      sel_in         = sel_ff;
      clr_in         = clr_ff;
      rsp_valid_in   = cmd.pull_emit;
      rsp_data_in    = rsp_data_ff;

      if (extra_we) begin
         extra_count_in = extra_count_ff + ECNT_W'(1);
      end
      if (main_we) begin
         main_count_in = main_count_ff + MCNT_W'(1);
      end
      if (cmd.dump_arm) begin
         dumping_in  = 1'b1;
         phase_in    = PH_HDR0;
         dump_idx_in = '0;
         sel_in      = '0;
      end
      if (cmd.clear_step) begin
         clr_in = clr_ff + IDX_W'(1);
      end

      if (cmd.pull_emit) begin
         rsp_data_in.last = 1'b0;
         case (phase_ff)
            PH_HDR0: begin
               rsp_data_in.out_byte = FRAME_BEGIN;
               phase_in             = PH_HDR1;
            end
            PH_HDR1: begin
               rsp_data_in.out_byte = total_sum[7:0];
               phase_in             = PH_HDR2;
            end
            PH_HDR2: begin
               rsp_data_in.out_byte = 8'(main_count_ff);
               dump_idx_in          = '0;
               sel_in               = '0;
               if (main_count_ff != '0) begin
                  phase_in = PH_MAIN;
               end else if (extra_count_ff != '0) begin
                  phase_in = PH_EXTRA;
               end else begin
                  phase_in = PH_END;
               end
            end
            PH_MAIN: begin
               case (sel_ff)
                  2'd0:    rsp_data_in.out_byte = MAIN_TAG;
                  2'd1:    rsp_data_in.out_byte = main_rd_ff[15:8];
                  default: rsp_data_in.out_byte = main_rd_ff[7:0];
               endcase
               if (sel_ff != 2'd2) begin
                  sel_in = sel_ff + 2'd1;
               end else begin
                  sel_in = '0;
                  if (dump_idx_ff + PTR_W'(1) == PTR_W'(main_count_ff)) begin
                     // main list done: move to the extra list
                     dump_idx_in = '0;
                     phase_in    = (extra_count_ff != '0) ? PH_EXTRA : PH_END;
                  end else begin
                     dump_idx_in = dump_idx_ff + PTR_W'(1);
                  end
               end
            end
            PH_EXTRA: begin
               case (sel_ff)
                  2'd0:    rsp_data_in.out_byte = extra_rd_ff[23:16];
                  2'd1:    rsp_data_in.out_byte = extra_rd_ff[15:8];
                  default: rsp_data_in.out_byte = extra_rd_ff[7:0];
               endcase
               if (sel_ff != 2'd2) begin
                  sel_in = sel_ff + 2'd1;
               end else begin
                  sel_in = '0;
                  if (dump_idx_ff + PTR_W'(1) == PTR_W'(extra_count_ff)) begin
                     dump_idx_in = '0;
                     phase_in    = PH_END;
                  end else begin
                     dump_idx_in = dump_idx_ff + PTR_W'(1);
                  end
               end
            end
            default: begin
               // closing byte: empty the lists and start the bitmap clear
               rsp_data_in.out_byte = FRAME_END;
               rsp_data_in.last     = 1'b1;
               main_count_in        = '0;
               extra_count_in       = '0;
               dumping_in           = 1'b0;
               phase_in             = PH_HDR0;
               dump_idx_in          = '0;
               sel_in               = '0;
               clr_in               = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_count_ff  <= '0;
         extra_count_ff <= '0;
         dumping_ff     <= 1'b0;
         phase_ff       <= PH_HDR0;
         dump_idx_ff    <= '0;
         sel_ff         <= '0;
         clr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         main_count_ff  <= main_count_in;
         extra_count_ff <= extra_count_in;
         dumping_ff     <= dumping_in;
         phase_ff       <= phase_in;
         dump_idx_ff    <= dump_idx_in;
         sel_ff         <= sel_in;
         clr_ff         <= clr_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.report_start) begin
         rep_id_ff       <= req_id;
         rep_in_range_ff <= req_in_range;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign sts.dumping    = dumping_ff;
   assign sts.at_end     = (phase_ff == PH_END);
   assign sts.clear_done = (clr_ff == IDX_W'(ID_COUNT - 1));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A result only follows an emit cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(cmd.pull_emit))
      else $error("result strobe without emit");

   assert property (@(posedge clock) disable iff (reset)
      main_count_ff <= MCNT_W'(MAIN_ENTRIES))
      else $error("main list count overflow");

   assert property (@(posedge clock) disable iff (reset)
      extra_count_ff <= ECNT_W'(EXTRA_ENTRIES))
      else $error("extra list count overflow");

   // After the closing byte the lists are empty and no dump runs
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.last) |->
         (!dumping_ff && main_count_ff == '0 && extra_count_ff == '0))
      else $error("dump did not wind up");

endmodule

`default_nettype wire

/* design/dedup_id_collector_with_report.sv */
// ----------------------------------------------------------------------------
// dedup_id_collector_with_report
// Tag report collector with a seen bitmap, main and extra lists, framed dump.
// ----------------------------------------------------------------------------
//  channel    ports                          handshake
//  request    start, busy, req_data          taken when start && !busy
//  result     rsp_valid, rsp_data            valid per byte, no back-pressure
//
//  A tag report reads the seen bitmap memory, then writes it.
//  A pull reads the list memory, then the byte is registered out.
//  A dump request, or any transaction that is dropped, leaves busy low.
//  After reset and after each closing 0xFE byte, busy stays high
//  while the bitmap is cleared one bit per cycle.
//  The result is held for one cycle only; the receiver must take it then.
// ----------------------------------------------------------------------------
`default_nettype none

module dedup_id_collector_with_report
   import didc_pkg::*;
#(
   parameter int MAIN_ENTRIES  = DEF_MAIN_ENTRIES,
   parameter int EXTRA_ENTRIES = DEF_EXTRA_ENTRIES,
   parameter int ID_COUNT      = DEF_ID_COUNT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   didc_cmd_type cmd;
   didc_sts_type sts;

   didc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .action (req_data.action),
      .sts    (sts),
      .cmd    (cmd),
      .busy   (busy)
   );

   didc_datapath #(
      .MAIN_ENTRIES  (MAIN_ENTRIES),
      .EXTRA_ENTRIES (EXTRA_ENTRIES),
      .ID_COUNT      (ID_COUNT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* sim/tb_dedup_id_collector_with_report.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dedup_id_collector_with_report
// Self-checking bench for the de-duplicating tag id collector. A directed
// table covers the edge cases: out-of-range ids, duplicates, dropped
// transactions, an unused action code and a complete frame. Random report
// batches follow, each closed by a framed dump. Every result byte is checked
// against the directed table or against a behavioral copy of the collector.
// ----------------------------------------------------------------------------

module tb_dedup_id_collector_with_report;
   import didc_pkg::*;

   localparam logic [1:0] ACT_UNUSED  = 2'd3;
   localparam int         ENTRY_BYTES = 3;
   localparam int         ITEM_GOAL   = 1500;
   localparam int         CYCLE_LIMIT = 1_000_000;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   // Collector model state
   bit [DEF_ID_COUNT-1:0] seen_ids;
   logic [15:0]           main_ids      [DEF_MAIN_ENTRIES];
   logic [23:0]           extra_reports [DEF_EXTRA_ENTRIES];
   int                    main_held;
   int                    extra_held;
   bit                    model_dumping;
   int                    frame_pos;

   rsp_type expected_bytes [$];
   rsp_type oldest_byte;
   int      error_count;
   int      took_count;
   int      idle_pct;
   int      cycle_count;

   dedup_id_collector_with_report i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [7:0] frame_byte_at(int p);
      int          q;
      int          sel;
      int          main_bytes;
      logic [23:0] word;
      main_bytes = main_held * ENTRY_BYTES;
      if (p == 0) return FRAME_BEGIN;
      if (p == 1) return 8'(main_held + extra_held);
      if (p == 2) return 8'(main_held);
      q = p - 3;
      if (q < main_bytes) begin
         word = {MAIN_TAG, main_ids[q / ENTRY_BYTES]};
      end else begin
         q    = q - main_bytes;
         word = extra_reports[q / ENTRY_BYTES];
      end
      sel = q % ENTRY_BYTES;
      return word[8 * (2 - sel) +: 8];
   endfunction

   // Advance the model by one transaction; took is low when it is ignored.
   task automatic collector_step(input req_type r, output bit got, output rsp_type o,
                                 output bit took);
      logic [15:0] tag_id;
      got  = 1'b0;
      took = 1'b0;
      o    = '0;
      tag_id = {r.id_high, r.id_low};
      case (r.action)
         ACT_REPORT: begin
            if (!model_dumping) begin
               took = 1'b1;
               if (tag_id < DEF_ID_COUNT && !seen_ids[tag_id]) begin
                  seen_ids[tag_id] = 1'b1;
                  if (main_held < DEF_MAIN_ENTRIES) begin
                     main_ids[main_held] = tag_id;
                     main_held++;
                  end
               end
               if (r.flag_byte != 8'h00 && extra_held < DEF_EXTRA_ENTRIES) begin
                  extra_reports[extra_held] = {r.flag_byte, r.id_high, r.id_low};
                  extra_held++;
               end
            end
         end
         ACT_DUMP: begin
            if (!model_dumping) begin
               took          = 1'b1;
               model_dumping = 1'b1;
               frame_pos     = 0;
            end
         end
         ACT_PULL: begin
            if (model_dumping) begin
               took = 1'b1;
               got  = 1'b1;
               if (frame_pos >= 3 + (main_held + extra_held) * ENTRY_BYTES) begin
                  o.out_byte    = FRAME_END;
                  o.last        = 1'b1;
                  seen_ids      = '0;
                  main_held     = 0;
                  extra_held    = 0;
                  model_dumping = 1'b0;
                  frame_pos     = 0;
               end else begin
                  o.out_byte = frame_byte_at(frame_pos);
                  o.last     = 1'b0;
                  frame_pos++;
               end
            end
         end
         default: ;
      endcase
   endtask

   // Hold the transaction until it is taken, then idle at random.
   task automatic issue_request(input req_type r, input bit typed, input rsp_type want);
      bit      got;
      bit      took;
      rsp_type predicted;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      collector_step(r, got, predicted, took);
      if (typed) begin
         expected_bytes.push_back(want);
      end else if (got) begin
         expected_bytes.push_back(predicted);
      end
      if (took) took_count++;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   function automatic req_type random_report();
      req_type r;
      int      pick;
      r.action    = ACT_REPORT;
      r.flag_byte = $urandom_range(1) ? 8'h00 : 8'($urandom_range(255));
      pick        = $urandom_range(9);
      if (pick < 3) begin
         // narrow id range to provoke duplicates
         r.id_high = 8'h00;
         r.id_low  = 8'($urandom_range(15));
      end else if (pick < 9) begin
         r.id_high = 8'($urandom_range(3));
         r.id_low  = 8'($urandom_range(255));
      end else begin
         r.id_high = 8'($urandom_range(255));
         r.id_low  = 8'($urandom_range(255));
      end
      return r;
   endfunction

   function automatic req_type random_item(logic [1:0] act);
      req_type r;
      r.action    = act;
      r.flag_byte = 8'($urandom_range(255));
      r.id_high   = 8'($urandom_range(255));
      r.id_low    = 8'($urandom_range(255));
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected result, expected none, got byte %02h last %0b",
                     $time, rsp_data.out_byte, rsp_data.last);
            error_count++;
         end else begin
            oldest_byte = expected_bytes.pop_front();
            if (rsp_data.out_byte !== oldest_byte.out_byte) begin
               $display("%0t: out_byte mismatch, expected %02h, got %02h",
                        $time, oldest_byte.out_byte, rsp_data.out_byte);
               error_count++;
            end
            if (rsp_data.last !== oldest_byte.last) begin
               $display("%0t: last mismatch, expected %0b, got %0b",
                        $time, oldest_byte.last, rsp_data.last);
               error_count++;
            end
         end
      end
   end

   stim_row_type directed_rows [26] = '{
      '{'{ACT_PULL,   8'h00, 8'h00, 8'h00}, 1'b0, '{8'h00, 1'b0}},  // pull with no dump
      '{'{ACT_UNUSED, 8'hFF, 8'hFF, 8'hFF}, 1'b0, '{8'h00, 1'b0}},
      '{'{ACT_REPORT, 8'h00, 8'h00, 8'h00}, 1'b0, '{8'h00, 1'b0}},
      '{'{ACT_REPORT, 8'hFF, 8'h03, 8'hFF}, 1'b0, '{8'h00, 1'b0}},  // highest id in range
      '{'{ACT_REPORT, 8'h00, 8'h04, 8'h00}, 1'b0, '{8'h00, 1'b0}},  // first id past bitmap
      '{'{ACT_REPORT, 8'h80, 8'hFF, 8'hFF}, 1'b0, '{8'h00, 1'b0}},
      '{'{ACT_REPORT, 8'h00, 8'h00, 8'h00}, 1'b0, '{8'h00, 1'b0}},  // duplicate
      '{'{ACT_DUMP,   8'h00, 8'h00, 8'h00}, 1'b0, '{8'h00, 1'b0}},
      '{'{ACT_DUMP,   8'hAA, 8'h55, 8'hAA}, 1'b0, '{8'h00, 1'b0}},  // ignored mid-dump
      '{'{ACT_REPORT, 8'h55, 8'h00, 8'h01}, 1'b0, '{8'h00, 1'b0}},  // dropped mid-dump
      '{'{ACT_PULL,   8'h00, 8'h00, 8'h00}, 1'b1, '{FRAME_BEGIN, 1'b0}},
      '{'{ACT_PULL,   8'h00, 8'h00, 8'h00}, 1'b1, '{8'h04, 1'b0}},
      '{'{ACT_PULL,   8'h00, 8'h00, 8'h00}, 1'b1, '{8'h02, 1'b0}},
      '{'{ACT_PULL,   8'h00, 8'h00, 8'h00}, 1'b1, '{MAIN_TAG, 1'b0}},
      '{'{ACT_PULL,   8'h00, 8'h00, 8'h00}, 1'b1, '{8'h00, 1'b0}},
      '{'{ACT_PULL,   8'h00, 8'h00, 8'h00}, 1'b1, '{8'h00, 1'b0}},
      '{'{ACT_PULL,   8'h00, 8'h00, 8'h00}, 1'b1, '{MAIN_TAG, 1'b0}},
      '{'{ACT_PULL,   8'h00, 8'h00, 8'h00}, 1'b1, '{8'h03, 1'b0}},
      '{'{ACT_PULL,   8'h00, 8'h00, 8'h00}, 1'b1, '{8'hFF, 1'b0}},
      '{'{ACT_PULL,   8'h00, 8'h00, 8'h00}, 1'b1, '{8'hFF, 1'b0}},
      '{'{ACT_PULL,   8'h00, 8'h00, 8'h00}, 1'b1, '{8'h03, 1'b0}},
      '{'{ACT_PULL,   8'h00, 8'h00, 8'h00}, 1'b1, '{8'hFF, 1'b0}},
      '{'{ACT_PULL,   8'h00, 8'h00, 8'h00}, 1'b1, '{8'h80, 1'b0}},
      '{'{ACT_PULL,   8'h00, 8'h00, 8'h00}, 1'b1, '{8'hFF, 1'b0}},
      '{'{ACT_PULL,   8'h00, 8'h00, 8'h00}, 1'b1, '{8'hFF, 1'b0}},
      '{'{ACT_PULL,   8'h00, 8'h00, 8'h00}, 1'b1, '{FRAME_END, 1'b1}}
   };

   initial begin
      int      batch_len;
      int      pulls;
      int      cut;
      bit      broken;
      rsp_type no_byte;
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      cycle_count = 0;
      error_count = 0;
      took_count  = 0;
      idle_pct    = 34;
      no_byte     = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         issue_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      end

      while (took_count < ITEM_GOAL) begin
         idle_pct  = (took_count < ITEM_GOAL / 3) ? 34 :
                     (took_count < 2 * ITEM_GOAL / 3) ? 88 : 0;
         batch_len = ($urandom_range(7) == 0) ? $urandom_range(60, 130) : $urandom_range(25);
         for (int i = 0; i < batch_len; i++) begin
            if ($urandom_range(9) == 0) begin
               issue_request(random_item(2'($urandom_range(3))), 1'b0, no_byte);
            end
            issue_request(random_report(), 1'b0, no_byte);
         end
         issue_request(random_item(ACT_DUMP), 1'b0, no_byte);
         // abandon some frames midway; the next batch resumes them
         broken = ($urandom_range(5) == 0);
         cut    = $urandom_range(1, 40);
         pulls  = 0;
         while (model_dumping && !(broken && pulls == cut)) begin
            if ($urandom_range(11) == 0) begin
               issue_request(random_item(2'($urandom_range(3))), 1'b0, no_byte);
            end
            issue_request(random_item(ACT_PULL), 1'b0, no_byte);
            pulls++;
         end
      end
      start <= 1'b0;

      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_bytes.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
